// File: rtl/core/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// Shared widths and fraction bit counts for the point-to-segment distance pipeline.
// ----------------------------------------------------------------------------
package psd_pkg;

  localparam int COORD_W         = 16;
  localparam int DIFF_W          = COORD_W + 1;
  localparam int SQ_W            = 2 * DIFF_W + 1;
  localparam int DIST_W          = 17;
  localparam int COORD_FRAC_BITS = 4;
  localparam int T_FRAC_BITS     = 16;

endpackage

// File: rtl/core/psd_if.sv
// ----------------------------------------------------------------------------
// psd_if
// Valid/ready channel carrying a payload of a given type.
// ----------------------------------------------------------------------------
interface psd_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/psd_div_cell.sv
// ----------------------------------------------------------------------------
// psd_div_cell
// One restoring division step: produce one quotient bit, pass the rest on.
// ----------------------------------------------------------------------------
module psd_div_cell
  import psd_pkg::*;
#(
  parameter int TW = T_FRAC_BITS
) (
  input  logic              clk,
  input  logic              en,
  input  logic [SQ_W-1:0]   rem_in,
  input  logic [SQ_W-1:0]   den_in,
  input  logic [TW:0]       q_in,
  output logic [SQ_W-1:0]   rem_out,
  output logic [SQ_W-1:0]   den_out,
  output logic [TW:0]       q_out
);

  logic [SQ_W:0] shifted;
  logic          take;

  assign shifted = {rem_in, 1'b0};
  assign take    = shifted >= {1'b0, den_in};

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= take ? SQ_W'(shifted - {1'b0, den_in}) : shifted[SQ_W-1:0];
      den_out <= den_in;
      q_out   <= {q_in[TW-1:0], take};
    end
  end

endmodule

// File: rtl/core/psd_sqrt_cell.sv
// ----------------------------------------------------------------------------
// psd_sqrt_cell
// One digit-by-digit square root step on a radix-4 pair.
// ----------------------------------------------------------------------------
module psd_sqrt_cell
  import psd_pkg::*;
#(
  parameter int VW = 2 * DIST_W + 2,
  parameter int RW = DIST_W + 1
) (
  input  logic          clk,
  input  logic          en,
  input  logic [VW-1:0] v_in,
  input  logic [RW-1:0] r_in,
  input  logic [RW+1:0] rem_in,
  output logic [VW-1:0] v_out,
  output logic [RW-1:0] r_out,
  output logic [RW+1:0] rem_out
);

  logic [RW+1:0] cur;
  logic [RW+1:0] trial;

  assign cur   = {rem_in[RW-1:0], v_in[VW-1 -: 2]};
  assign trial = {r_in, 2'b01};

  always_ff @(posedge clk) begin
    if (en) begin
      v_out <= {v_in[VW-3:0], 2'b00};
      if (cur >= trial) begin
        rem_out <= cur - trial;
        r_out   <= {r_in[RW-2:0], 1'b1};
      end else begin
        rem_out <= cur;
        r_out   <= {r_in[RW-2:0], 1'b0};
      end
    end
  end

endmodule

// File: rtl/core/point_segment_distance.sv
// ----------------------------------------------------------------------------
// point_segment_distance
// Distance from a point to a segment, fully pipelined through a row of
// divider cells and a row of square root cells.
// ----------------------------------------------------------------------------
// channel   dir  payload
// in_ch     in   px py ax ay bx by (signed Q11.4)
// out_ch    out  distance (unsigned Q.4)
//
// One item per cycle while the output is not stalled. Stages: 3 setup stages, T_FRAC_BITS+1
// divider cells, 2 projection stages, 1 square stage, 18 root cells.
// The whole pipe advances when the output register is empty or taken.
// Reset clears only the valid bits.
// ----------------------------------------------------------------------------
module point_segment_distance
  import psd_pkg::*;
#(
  parameter int TW = T_FRAC_BITS
) (
  input logic  clk,
  input logic  rst,
  psd_if.sink   in_ch,
  psd_if.source out_ch
);

  localparam int NDIV = TW + 1;
  localparam int NSQ  = DIST_W + 1;
  localparam int VW   = 2 * NSQ;
  localparam int RW   = NSQ;
  localparam int PW   = DIFF_W + TW + 2;
  localparam int NST  = 3 + NDIV + 3 + NSQ;

  localparam logic [1:0] MODE_DIV  = 2'd0;
  localparam logic [1:0] MODE_ZERO = 2'd1;
  localparam logic [1:0] MODE_ONE  = 2'd2;

  logic adv;
  logic [NST-1:0] vld;

  assign adv         = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], in_ch.valid};
    end
  end

  // stage 0: differences
  logic signed [DIFF_W-1:0] s0_abx, s0_aby, s0_apx, s0_apy;
  logic signed [COORD_W-1:0] s0_ax, s0_ay, s0_px, s0_py;
  always_ff @(posedge clk) begin
    if (adv) begin
      s0_abx <= DIFF_W'(in_ch.data.bx) - DIFF_W'(in_ch.data.ax);
      s0_aby <= DIFF_W'(in_ch.data.by) - DIFF_W'(in_ch.data.ay);
      s0_apx <= DIFF_W'(in_ch.data.px) - DIFF_W'(in_ch.data.ax);
      s0_apy <= DIFF_W'(in_ch.data.py) - DIFF_W'(in_ch.data.ay);
      s0_ax <= in_ch.data.ax;
      s0_ay <= in_ch.data.ay;
      s0_px <= in_ch.data.px;
      s0_py <= in_ch.data.py;
    end
  end

  // stage 1: products
  logic signed [SQ_W-1:0] s1_l0, s1_l1, s1_d0, s1_d1;
  logic signed [DIFF_W-1:0] s1_abx, s1_aby;
  logic signed [COORD_W-1:0] s1_ax, s1_ay, s1_px, s1_py;
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_l0 <= SQ_W'(s0_abx * s0_abx);
      s1_l1 <= SQ_W'(s0_aby * s0_aby);
      s1_d0 <= SQ_W'(s0_apx * s0_abx);
      s1_d1 <= SQ_W'(s0_apy * s0_aby);
      s1_abx <= s0_abx; s1_aby <= s0_aby;
      s1_ax <= s0_ax; s1_ay <= s0_ay; s1_px <= s0_px; s1_py <= s0_py;
    end
  end

  // stage 2: sums and clamp decision
  logic [SQ_W-1:0] s1_len2;
  logic signed [SQ_W:0] s1_dot;
  logic [SQ_W-1:0] s2_num, s2_den;
  logic [1:0] s2_mode;
  logic signed [DIFF_W-1:0] s2_abx, s2_aby;
  logic signed [COORD_W-1:0] s2_ax, s2_ay, s2_px, s2_py;
  assign s1_len2 = s1_l0 + s1_l1;
  assign s1_dot  = (SQ_W+1)'(s1_d0) + (SQ_W+1)'(s1_d1);
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_den <= s1_len2;
      s2_num <= s1_dot[SQ_W-1:0];
      if (s1_len2 == '0 || s1_dot <= 0) begin
        s2_mode <= MODE_ZERO;
      end else if (s1_dot >= $signed({1'b0, s1_len2})) begin
        s2_mode <= MODE_ONE;
      end else begin
        s2_mode <= MODE_DIV;
      end
      s2_abx <= s1_abx; s2_aby <= s1_aby;
      s2_ax <= s1_ax; s2_ay <= s1_ay; s2_px <= s1_px; s2_py <= s1_py;
    end
  end

  // divider chain: remainder starts as num, each cell one quotient bit
  logic [SQ_W-1:0] dr [NDIV+1];
  logic [SQ_W-1:0] dd [NDIV+1];
  logic [TW:0]     dq [NDIV+1];
  logic [1:0]      dm [NDIV+1];
  logic signed [DIFF_W-1:0] dabx [NDIV+1], daby [NDIV+1];
  logic signed [COORD_W-1:0] dax [NDIV+1], day [NDIV+1], dpx [NDIV+1], dpy [NDIV+1];

  assign dr[0] = s2_num;
  assign dd[0] = s2_den;
  assign dq[0] = '0;
  assign dm[0] = s2_mode;
  assign dabx[0] = s2_abx; assign daby[0] = s2_aby;
  assign dax[0] = s2_ax; assign day[0] = s2_ay;
  assign dpx[0] = s2_px; assign dpy[0] = s2_py;

  for (genvar i = 0; i < NDIV; i++) begin : g_div
    // first cell divides num (not shifted) to get the integer bit
    if (i == 0) begin : g_first
      logic take;
      assign take = dr[0] >= dd[0];
      always_ff @(posedge clk) begin
        if (adv) begin
          dr[1] <= take ? dr[0] - dd[0] : dr[0];
          dd[1] <= dd[0];
          dq[1] <= {dq[0][TW-1:0], take};
        end
      end
    end else begin : g_rest
      psd_div_cell #(.TW(TW)) u_cell (
        .clk(clk), .en(adv),
        .rem_in(dr[i]), .den_in(dd[i]), .q_in(dq[i]),
        .rem_out(dr[i+1]), .den_out(dd[i+1]), .q_out(dq[i+1])
      );
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dm[i+1] <= dm[i];
        dabx[i+1] <= dabx[i]; daby[i+1] <= daby[i];
        dax[i+1] <= dax[i]; day[i+1] <= day[i];
        dpx[i+1] <= dpx[i]; dpy[i+1] <= dpy[i];
      end
    end
  end

  // projection stage A: t select and scale products
  logic [TW:0] t_sel;
  logic [PW-1:0] pa_mx, pa_my;
  logic pa_nx, pa_ny;
  logic [DIFF_W-1:0] magx, magy;
  logic signed [COORD_W-1:0] pa_ax, pa_ay, pa_px, pa_py;
  always_comb begin
    case (dm[NDIV])
      MODE_ZERO: t_sel = '0;
      MODE_ONE:  t_sel = (TW+1)'(1) << TW;
      default:   t_sel = dq[NDIV];
    endcase
  end
  assign magx = dabx[NDIV][DIFF_W-1] ? DIFF_W'(-dabx[NDIV]) : DIFF_W'(dabx[NDIV]);
  assign magy = daby[NDIV][DIFF_W-1] ? DIFF_W'(-daby[NDIV]) : DIFF_W'(daby[NDIV]);
  always_ff @(posedge clk) begin
    if (adv) begin
      pa_mx <= PW'(magx) * PW'(t_sel);
      pa_my <= PW'(magy) * PW'(t_sel);
      pa_nx <= dabx[NDIV][DIFF_W-1];
      pa_ny <= daby[NDIV][DIFF_W-1];
      pa_ax <= dax[NDIV]; pa_ay <= day[NDIV];
      pa_px <= dpx[NDIV]; pa_py <= dpy[NDIV];
    end
  end

  // projection stage B: round, offset, residual
  logic [PW-1:0] qx, qy;
  logic signed [DIFF_W+1:0] ex, ey;
  logic signed [DIFF_W+1:0] pb_dx, pb_dy;
  assign qx = (pa_mx + (PW'(1) << (TW-1))) >> TW;
  assign qy = (pa_my + (PW'(1) << (TW-1))) >> TW;
  assign ex = pa_nx ? -$signed((DIFF_W+2)'(qx)) : $signed((DIFF_W+2)'(qx));
  assign ey = pa_ny ? -$signed((DIFF_W+2)'(qy)) : $signed((DIFF_W+2)'(qy));
  always_ff @(posedge clk) begin
    if (adv) begin
      pb_dx <= (DIFF_W+2)'(pa_px) - (DIFF_W+2)'(pa_ax) - ex;
      pb_dy <= (DIFF_W+2)'(pa_py) - (DIFF_W+2)'(pa_ay) - ey;
    end
  end

  // square stage
  logic [VW-1:0] sq;
  always_ff @(posedge clk) begin
    if (adv) begin
      sq <= VW'(pb_dx * pb_dx) + VW'(pb_dy * pb_dy);
    end
  end

  // root chain
  logic [VW-1:0] rv [NSQ+1];
  logic [RW-1:0] rr [NSQ+1];
  logic [RW+1:0] rm [NSQ+1];
  assign rv[0] = sq;
  assign rr[0] = '0;
  assign rm[0] = '0;
  for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
    psd_sqrt_cell #(.VW(VW), .RW(RW)) u_cell (
      .clk(clk), .en(adv),
      .v_in(rv[j]), .r_in(rr[j]), .rem_in(rm[j]),
      .v_out(rv[j+1]), .r_out(rr[j+1]), .rem_out(rm[j+1])
    );
  end

  assign out_ch.valid         = vld[NST-1];
  assign out_ch.data.distance = rr[NSQ][DIST_W-1:0];

endmodule

// File: rtl/core/psd_checker.sv
// ----------------------------------------------------------------------------
// psd_port_checker
// Port-level checks for the distance pipeline.
// ----------------------------------------------------------------------------
module psd_port_checker
  import psd_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DIST_W-1:0] distance
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(distance))
    else $error("output not held under stall");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output");

  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind point_segment_distance psd_port_checker u_psd_checker (
  .clk(clk), .rst(rst),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .distance(out_ch.data.distance)
);
